@@ rtl/core/hctl_pkg.sv @@
// ----------------------------------------------------------------------------
// hctl_pkg
// Types and codes shared by the heat/cool thermostat lockout core.
// ----------------------------------------------------------------------------
package hctl_pkg;

  // Milliseconds in one second, used to arm deadlines and round lockouts
  localparam logic [9:0] MS_PER_SEC = 10'd1000;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_HEATING   = 3'd1,
    ST_COOLING   = 3'd2,
    ST_LOCK_HEAT = 3'd3,
    ST_LOCK_COOL = 3'd4,
    ST_FAULT     = 3'd5
  } ctrl_state_t;

  typedef enum logic [3:0] {
    RS_IDLE         = 4'd0,
    RS_INACTIVE     = 4'd1,
    RS_SENSOR       = 4'd2,
    RS_HEAT_LIMITED = 4'd3,
    RS_COOL_LIMITED = 4'd4,
    RS_HEAT_DELAY   = 4'd5,
    RS_COOL_DELAY   = 4'd6,
    RS_HEATING      = 4'd7,
    RS_COOLING      = 4'd8,
    RS_HYSTERESIS   = 4'd9
  } reason_t;

  typedef enum logic [2:0] {
    REG_CONTROL_ENABLED = 3'd0,
    REG_SETPOINT        = 3'd1,
    REG_BAND            = 3'd2,
    REG_CHAMBER_LIMIT   = 3'd3,
    REG_CHAMBER_BAND    = 3'd4,
    REG_HEAT_DELAY      = 3'd5,
    REG_COOL_DELAY      = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]  idx;
    logic [15:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic               control_enabled;
    logic signed [14:0] setpoint;
    logic [10:0]        band;
    logic               chamber_limit_enabled;
    logic [11:0]        chamber_band;
    logic [15:0]        heat_delay_seconds;
    logic [15:0]        cool_delay_seconds;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               primary_valid;
    logic signed [15:0] primary_temp;
    logic               secondary_valid;
    logic signed [15:0] secondary_temp;
  } in_item_t;

  typedef struct packed {
    ctrl_state_t ctrl_state;
    reason_t     reason_code;
    logic [21:0] lock_seconds;
    logic        heater_on;
    logic        cooler_on;
    logic        heat_demand;
    logic        cool_demand;
    logic        auto_active;
    logic        changed;
  } out_item_t;

endpackage

@@ rtl/core/hctl_chan_if.sv @@
// ----------------------------------------------------------------------------
// hctl_chan_if
// Valid/ready channel carrying one item of a chosen payload type.
// ----------------------------------------------------------------------------
interface hctl_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/hctl_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// hctl_cfg_regs
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module hctl_cfg_regs import hctl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  hctl_chan_if.sink   cfg_wr,
  output cfg_t        cfg
);

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.control_enabled       <= 1'b0;
      cfg.setpoint              <= 15'sd2000;
      cfg.band                  <= 11'd50;
      cfg.chamber_limit_enabled <= 1'b0;
      cfg.chamber_band          <= 12'd200;
      cfg.heat_delay_seconds    <= 16'd0;
      cfg.cool_delay_seconds    <= 16'd0;
    end else if (cfg_wr.valid) begin
      case (cfg_reg_t'(cfg_wr.data.idx))
        REG_CONTROL_ENABLED: cfg.control_enabled       <= cfg_wr.data.wdata[0];
        REG_SETPOINT:        cfg.setpoint              <= cfg_wr.data.wdata[14:0];
        REG_BAND:            cfg.band                  <= cfg_wr.data.wdata[10:0];
        REG_CHAMBER_LIMIT:   cfg.chamber_limit_enabled <= cfg_wr.data.wdata[0];
        REG_CHAMBER_BAND:    cfg.chamber_band          <= cfg_wr.data.wdata[11:0];
        REG_HEAT_DELAY:      cfg.heat_delay_seconds    <= cfg_wr.data.wdata;
        REG_COOL_DELAY:      cfg.cool_delay_seconds    <= cfg_wr.data.wdata;
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

endmodule

@@ rtl/core/hctl_lock_calc.sv @@
// ----------------------------------------------------------------------------
// hctl_lock_calc
// Remaining lockout time in whole seconds, rounded up, for one deadline.
// ----------------------------------------------------------------------------
module hctl_lock_calc import hctl_pkg::*; (
  input  logic [31:0] deadline,
  input  logic [31:0] now_ms,
  output logic [21:0] lock_seconds
);

  // ceil(2^41 / 1000): exact floor division for every 32-bit dividend
  localparam logic [31:0] RECIP = 32'd2199023256;

  logic [31:0] diff;
  logic        active;
  logic [31:0] rounded;
  logic [63:0] prod;

  assign diff    = deadline - now_ms;
  // a deadline of zero means no lock; a past deadline reads as negative
  assign active  = (deadline != 32'd0) && (diff != 32'd0) && !diff[31];
  // diff stays below 2^31 here, so adding the rounding term cannot wrap
  assign rounded = diff + 32'(MS_PER_SEC - 10'd1);
  assign prod    = {32'd0, rounded} * {32'd0, RECIP};

  assign lock_seconds = active ? prod[62:41] : 22'd0;

endmodule

@@ rtl/core/heat_cool_thermostat_lockout_core.sv @@
// ----------------------------------------------------------------------------
// heat_cool_thermostat_lockout_core
// Path: an accepted tick waits in the tick register, then its result moves to
// the result register. Throughput: 1 item per cycle while results are taken,
// set by the single evaluation stage whose state feedback (output levels,
// deadlines, chamber latches, last result) closes combinationally; a stalled
// result holds one more item in the tick register, then drops tick.ready.
// Reset (rst, synchronous): control and controller state return to defaults.
// ----------------------------------------------------------------------------
module heat_cool_thermostat_lockout_core import hctl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  hctl_chan_if.sink   cfg_wr,
  hctl_chan_if.sink   tick,
  hctl_chan_if.source result
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cfg_t cfg;

  hctl_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst    (rst),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  // --------------------------------------------------------------------------
  // Pipeline control: tick register feeds the result register. Advance when
  // the result register is empty or its item is being taken, so a new tick
  // can enter every cycle while results are taken.
  // --------------------------------------------------------------------------
  logic      in_full;
  in_item_t  item;
  logic      out_full;
  out_item_t out_item;
  logic      advance;

  assign advance     = in_full && (!out_full || result.ready);
  assign tick.ready  = !in_full || advance;
  assign result.valid = out_full;
  assign result.data  = out_item;

  // --------------------------------------------------------------------------
  // Controller state
  // --------------------------------------------------------------------------
  logic        heater_level, cooler_level;
  logic [31:0] heat_deadline, cool_deadline;
  logic        heat_blocked, cool_blocked;
  ctrl_state_t last_state;
  reason_t     last_reason;
  logic [21:0] last_lock_seconds;

  logic        heater_level_next, cooler_level_next;
  logic [31:0] heat_deadline_next, cool_deadline_next;
  logic        heat_blocked_next, cool_blocked_next;
  out_item_t   res;

  // --------------------------------------------------------------------------
  // Thresholds, all in 18-bit signed centidegrees so no sum can overflow
  // --------------------------------------------------------------------------
  logic signed [17:0] sp_w, band_w, cband_w, chalf_w;
  logic signed [17:0] temp_w, sec_w;
  logic signed [17:0] heat_thr, cool_thr;
  logic signed [17:0] cool_set_thr, cool_rel_thr, heat_set_thr, heat_rel_thr;
  logic               hd, cd;

  assign sp_w    = {{3{cfg.setpoint[14]}}, cfg.setpoint};
  assign band_w  = {7'd0, cfg.band};
  assign cband_w = {6'd0, cfg.chamber_band};
  // half of the chamber band, truncated
  assign chalf_w = {7'd0, cfg.chamber_band[11:1]};
  assign temp_w  = {{2{item.primary_temp[15]}}, item.primary_temp};
  assign sec_w   = {{2{item.secondary_temp[15]}}, item.secondary_temp};

  assign heat_thr     = sp_w - band_w;
  assign cool_thr     = sp_w + band_w;
  assign cool_set_thr = sp_w - cband_w;
  assign cool_rel_thr = sp_w - chalf_w;
  assign heat_set_thr = sp_w + cband_w;
  assign heat_rel_thr = sp_w + chalf_w;

  // Heat demand wins; cool demand is only looked at when heat is not asked
  assign hd = (temp_w <= heat_thr);
  assign cd = !hd && (temp_w >= cool_thr);

  // --------------------------------------------------------------------------
  // Lockout remaining: only one output's deadline matters for a given tick
  // --------------------------------------------------------------------------
  logic [21:0] lock_left;

  hctl_lock_calc u_lock_calc (
    .deadline     (hd ? heat_deadline : cool_deadline),
    .now_ms       (item.now_ms),
    .lock_seconds (lock_left)
  );

  // Deadlines armed by this tick, wrapping modulo 2^32
  logic [31:0] heat_arm, cool_arm;

  assign heat_arm = item.now_ms + (32'(cfg.heat_delay_seconds) * 32'(MS_PER_SEC));
  assign cool_arm = item.now_ms + (32'(cfg.cool_delay_seconds) * 32'(MS_PER_SEC));

  // --------------------------------------------------------------------------
  // Evaluate one tick against the current state
  // --------------------------------------------------------------------------
  always_comb begin
    heater_level_next  = heater_level;
    cooler_level_next  = cooler_level;
    heat_deadline_next = heat_deadline;
    cool_deadline_next = cool_deadline;
    heat_blocked_next  = heat_blocked;
    cool_blocked_next  = cool_blocked;

    res.ctrl_state   = ST_IDLE;
    res.reason_code  = RS_IDLE;
    res.lock_seconds = 22'd0;
    res.heat_demand  = 1'b0;
    res.cool_demand  = 1'b0;
    res.auto_active  = 1'b0;

    if (!cfg.control_enabled) begin
      // inactive: both outputs off, latches and deadlines hold
      heater_level_next = 1'b0;
      cooler_level_next = 1'b0;
      res.reason_code   = RS_INACTIVE;
    end else if (!item.primary_valid) begin
      // primary sensor lost: both outputs off, report a fault
      heater_level_next = 1'b0;
      cooler_level_next = 1'b0;
      res.ctrl_state    = ST_FAULT;
      res.reason_code   = RS_SENSOR;
    end else begin
      res.auto_active = 1'b1;
      res.heat_demand = hd;
      res.cool_demand = cd;

      // Chamber limit latches with half-band release
      if (!cfg.chamber_limit_enabled || !item.secondary_valid) begin
        heat_blocked_next = 1'b0;
        cool_blocked_next = 1'b0;
      end else begin
        if (cool_blocked) begin
          cool_blocked_next = !(sec_w > cool_rel_thr);
        end else begin
          cool_blocked_next = (sec_w < cool_set_thr);
        end
        if (heat_blocked) begin
          heat_blocked_next = !(sec_w < heat_rel_thr);
        end else begin
          heat_blocked_next = (sec_w > heat_set_thr);
        end
      end

      if (hd && heat_blocked_next) begin
        // limited: drop the heater, arm nothing
        heater_level_next = 1'b0;
        res.reason_code   = RS_HEAT_LIMITED;
      end else if (cd && cool_blocked_next) begin
        cooler_level_next = 1'b0;
        res.reason_code   = RS_COOL_LIMITED;
      end else if (hd) begin
        res.lock_seconds = lock_left;
        if (lock_left != 22'd0) begin
          // locked: outputs hold
          res.ctrl_state  = ST_LOCK_HEAT;
          res.reason_code = RS_HEAT_DELAY;
        end else begin
          heater_level_next = 1'b1;
          cooler_level_next = 1'b0;
          if (!heater_level) begin
            cool_deadline_next = cool_arm;
          end
          res.ctrl_state  = ST_HEATING;
          res.reason_code = RS_HEATING;
        end
      end else if (cd) begin
        res.lock_seconds = lock_left;
        if (lock_left != 22'd0) begin
          res.ctrl_state  = ST_LOCK_COOL;
          res.reason_code = RS_COOL_DELAY;
        end else begin
          cooler_level_next = 1'b1;
          heater_level_next = 1'b0;
          if (!cooler_level) begin
            heat_deadline_next = heat_arm;
          end
          res.ctrl_state  = ST_COOLING;
          res.reason_code = RS_COOLING;
        end
      end else begin
        // inside the band: switch off and arm the other side's lockout
        heater_level_next = 1'b0;
        cooler_level_next = 1'b0;
        if (heater_level) begin
          cool_deadline_next = cool_arm;
        end
        if (cooler_level) begin
          heat_deadline_next = heat_arm;
        end
        res.reason_code = RS_HYSTERESIS;
      end
    end

    res.heater_on = heater_level_next;
    res.cooler_on = cooler_level_next;
    res.changed   = (res.ctrl_state != last_state) ||
                    (res.reason_code != last_reason) ||
                    (res.lock_seconds != last_lock_seconds) ||
                    (heater_level_next != heater_level) ||
                    (cooler_level_next != cooler_level);
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full           <= 1'b0;
      out_full          <= 1'b0;
      heater_level      <= 1'b0;
      cooler_level      <= 1'b0;
      heat_deadline     <= 32'd0;
      cool_deadline     <= 32'd0;
      heat_blocked      <= 1'b0;
      cool_blocked      <= 1'b0;
      last_state        <= ST_IDLE;
      last_reason       <= RS_IDLE;
      last_lock_seconds <= 22'd0;
    end else begin
      // tick register: load on accept, empty when its item moves on
      if (tick.valid && tick.ready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end

      // result register: load on advance, empty when the item is taken
      if (advance) begin
        out_full <= 1'b1;
      end else if (result.ready) begin
        out_full <= 1'b0;
      end

      // commit the state a tick leaves as it moves to the result register
      if (advance) begin
        heater_level      <= heater_level_next;
        cooler_level      <= cooler_level_next;
        heat_deadline     <= heat_deadline_next;
        cool_deadline     <= cool_deadline_next;
        heat_blocked      <= heat_blocked_next;
        cool_blocked      <= cool_blocked_next;
        last_state        <= res.ctrl_state;
        last_reason       <= res.reason_code;
        last_lock_seconds <= res.lock_seconds;
      end
    end
  end

  // payload registers need no reset
  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      item <= tick.data;
    end
    if (advance) begin
      out_item <= res;
    end
  end

endmodule
